// ----- rtl/yuvbd_pkg.sv -----
// Shared types and constants of the YUV box downscaler.
package yuvbd_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int COL_W         = 13;
    localparam int ROW_W         = 13;
    localparam int DIM_W         = 14;
    localparam int ADD_W         = 12;
    localparam int SUM_W         = 15;
    localparam int PIX_W         = 3 * SAMPLE_W;
    localparam int MAX_WIDTH_DEF = 8192;
    localparam int MAX_HEIGHT    = 8192;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;
    localparam int CFG_IDX_W     = 3;

    // What the back end does with one queued item.
    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_STORE0,
        KIND_STORE1,
        KIND_STORE2,
        KIND_ACC2,
        KIND_ACC4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [COL_W-1:0]     col;
        logic                 restart;
        logic                 emit;
        logic [SAMPLE_W-1:0]  luma;
        logic [SAMPLE_W-1:0]  cb;
        logic [SAMPLE_W-1:0]  cr;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

endpackage

// ----- rtl/yuv_box_downscale.sv -----
// Top level of the YUV box downscaler: front end, item queue and back end.
//
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  i_s_tdata: luma_in, cb_in, cr_in
//  m         out        o_m_tvalid/i_m_tready  o_m_tdata: luma_out, cb_out, cr_out
//  cfg       in         i_cfg_we               i_cfg_index, i_cfg_data
//
// One item per cycle is taken while the queue has room, and one result per cycle can
// leave; each line store is read and written once per cycle, which sets that rate.
// An accepted item passes the queue, the s1 and s2 registers and the output register.
// Reset is synchronous and clears counters, sums and valids; line stores are not cleared.
// A stalled output freezes the back end only; the four-entry queue keeps taking items
// until it fills, and only then is the input held off.
module yuv_box_downscale #(
    parameter int MAX_WIDTH = yuvbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [yuvbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [yuvbd_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,  // luma_in, cb_in, cr_in, zero pad
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [31:0]                      o_m_tdata   // luma_out, cb_out, cr_out, zero pad
);

    localparam int SW = yuvbd_pkg::SAMPLE_W;

    yuvbd_pkg::t_push   w_push;
    yuvbd_pkg::t_op     w_head;
    logic               w_head_valid;
    logic               w_pop;
    logic [SW-1:0]      w_luma, w_cb, w_cr;

    yuvbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_tvalid),
        .i_queue_ready (o_s_tready),
        .i_luma        (i_s_tdata[SW-1:0]),
        .i_cb          (i_s_tdata[2*SW-1:SW]),
        .i_cr          (i_s_tdata[3*SW-1:2*SW]),
        .o_push        (w_push)
    );

    yuvbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_ready (o_s_tready),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    yuvbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_luma       (w_luma),
        .o_cb         (w_cb),
        .o_cr         (w_cr)
    );

    assign o_m_tdata = {2'b00, w_cr, w_cb, w_luma};

endmodule

// ----- rtl/yuvbd_front.sv -----
// Front end: configuration registers, frame counters and item classification.
module yuvbd_front #(
    parameter int MAX_WIDTH = yuvbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [yuvbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [yuvbd_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    input  logic                                i_queue_ready,
    input  logic [yuvbd_pkg::SAMPLE_W-1:0]      i_luma,
    input  logic [yuvbd_pkg::SAMPLE_W-1:0]      i_cb,
    input  logic [yuvbd_pkg::SAMPLE_W-1:0]      i_cr,
    output yuvbd_pkg::t_push                    o_push
);

    localparam logic [yuvbd_pkg::CFG_IDX_W-1:0] REG_SCALE_ENABLE  = 3'd0;
    localparam logic [yuvbd_pkg::CFG_IDX_W-1:0] REG_PIXEL_PATTERN = 3'd1;
    localparam logic [yuvbd_pkg::CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd2;
    localparam logic [yuvbd_pkg::CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd3;
    localparam logic [yuvbd_pkg::CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd4;

    localparam logic [1:0] PATTERN_PLANAR = 2'd0;
    localparam logic [2:0] FACTOR_2       = 3'd2;
    localparam logic [2:0] FACTOR_4       = 3'd4;

    localparam logic [yuvbd_pkg::DIM_W-1:0] MAX_W = yuvbd_pkg::DIM_W'(MAX_WIDTH);
    localparam logic [yuvbd_pkg::DIM_W-1:0] MAX_H = yuvbd_pkg::DIM_W'(yuvbd_pkg::MAX_HEIGHT);
    localparam logic [yuvbd_pkg::DIM_W-1:0] ONE   = yuvbd_pkg::DIM_W'(1);

    logic                            r_enable;
    logic [1:0]                      r_pattern;
    logic [2:0]                      r_factor;
    logic [yuvbd_pkg::DIM_W-1:0]     r_width;
    logic [yuvbd_pkg::DIM_W-1:0]     r_height;
    logic [yuvbd_pkg::COL_W-1:0]     r_col;
    logic [yuvbd_pkg::ROW_W-1:0]     r_row;
    logic [yuvbd_pkg::COL_W-1:0]     n_col;
    logic [yuvbd_pkg::ROW_W-1:0]     n_row;

    logic [yuvbd_pkg::DIM_W-1:0]     w_width;
    logic [yuvbd_pkg::DIM_W-1:0]     w_height;
    logic [yuvbd_pkg::COL_W-1:0]     w_col;
    logic [yuvbd_pkg::DIM_W-1:0]     w_col_inc;
    logic [yuvbd_pkg::DIM_W-1:0]     w_row_inc;
    logic                            w_accept;
    logic                            w_drop;
    yuvbd_pkg::t_op                  w_op;

    assign w_accept = i_valid && i_queue_ready;

    // A zero size acts as one; oversize values saturate.
    assign w_width  = (r_width == '0) ? ONE : ((r_width > MAX_W) ? MAX_W : r_width);
    assign w_height = (r_height == '0) ? ONE : ((r_height > MAX_H) ? MAX_H : r_height);
    assign w_col    = ({1'b0, r_col} >= MAX_W) ? '0 : r_col;
    assign w_col_inc = {1'b0, w_col} + ONE;
    assign w_row_inc = {1'b0, r_row} + ONE;

    always_comb begin
        if (w_col_inc >= w_width) begin
            n_col = '0;
            n_row = (w_row_inc >= w_height) ? '0 : w_row_inc[yuvbd_pkg::ROW_W-1:0];
        end else begin
            n_col = w_col_inc[yuvbd_pkg::COL_W-1:0];
            n_row = r_row;
        end
    end

    always_comb begin
        w_drop     = 1'b0;
        w_op.kind  = yuvbd_pkg::KIND_PASS;
        w_op.col   = w_col;
        w_op.restart = 1'b0;
        w_op.emit  = 1'b0;
        w_op.luma  = i_luma;
        w_op.cb    = i_cb;
        w_op.cr    = i_cr;
        priority if (!r_enable) begin
            w_op.emit = 1'b1;
        end else if (r_pattern == PATTERN_PLANAR && r_factor == FACTOR_2) begin
            if (!r_row[0]) begin
                w_op.kind = yuvbd_pkg::KIND_STORE0;
            end else begin
                w_op.kind    = yuvbd_pkg::KIND_ACC2;
                w_op.restart = !w_col[0];
                w_op.emit    = w_col[0];
            end
        end else if (r_pattern == PATTERN_PLANAR && r_factor == FACTOR_4) begin
            unique case (r_row[1:0])
                2'd0: w_op.kind = yuvbd_pkg::KIND_STORE0;
                2'd1: w_op.kind = yuvbd_pkg::KIND_STORE1;
                2'd2: w_op.kind = yuvbd_pkg::KIND_STORE2;
                default: begin
                    w_op.kind    = yuvbd_pkg::KIND_ACC4;
                    w_op.restart = (w_col[1:0] == 2'd0);
                    w_op.emit    = (w_col[1:0] == 2'd3);
                end
            endcase
        end else begin
            // Unsupported mode: the item is consumed and still advances the position, but is not queued.
            w_drop = 1'b1;
        end
    end

    assign o_push.push = w_accept && !w_drop;
    assign o_push.op   = w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_pattern <= 2'd0;
            r_factor  <= FACTOR_2;
            r_width   <= yuvbd_pkg::DIM_W'(1920);
            r_height  <= yuvbd_pkg::DIM_W'(1080);
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SCALE_ENABLE:  r_enable  <= i_cfg_data[0];
                    REG_PIXEL_PATTERN: r_pattern <= i_cfg_data[1:0];
                    REG_SCALE_FACTOR:  r_factor  <= i_cfg_data[2:0];
                    REG_FRAME_WIDTH:   r_width   <= i_cfg_data;
                    REG_FRAME_HEIGHT:  r_height  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ----- rtl/yuvbd_queue.sv -----
// Short queue of classified items between the front and back ends.
module yuvbd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  yuvbd_pkg::t_push   i_push,
    input  logic               i_pop,
    output logic               o_ready,
    output logic               o_valid,
    output yuvbd_pkg::t_op     o_head
);

    localparam logic [yuvbd_pkg::QPTR_W:0] FULL =
        (yuvbd_pkg::QPTR_W + 1)'(yuvbd_pkg::QUEUE_DEPTH);

    yuvbd_pkg::t_op                  r_mem [yuvbd_pkg::QUEUE_DEPTH];
    logic [yuvbd_pkg::QPTR_W-1:0]    r_wr;
    logic [yuvbd_pkg::QPTR_W-1:0]    r_rd;
    logic [yuvbd_pkg::QPTR_W:0]      r_count;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> r_count != FULL)
        else $error("item pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("item popped from an empty queue");

endmodule

// ----- rtl/yuvbd_back.sv -----
// Back end: line stores, column sums, block accumulation and output register.
module yuvbd_back #(
    parameter int MAX_WIDTH = yuvbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  yuvbd_pkg::t_op                  i_head,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [yuvbd_pkg::SAMPLE_W-1:0]  o_luma,
    output logic [yuvbd_pkg::SAMPLE_W-1:0]  o_cb,
    output logic [yuvbd_pkg::SAMPLE_W-1:0]  o_cr
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int SW     = yuvbd_pkg::SAMPLE_W;

    logic [yuvbd_pkg::PIX_W-1:0]  r_mem0 [MAX_WIDTH];
    logic [yuvbd_pkg::PIX_W-1:0]  r_mem1 [MAX_WIDTH];
    logic [yuvbd_pkg::PIX_W-1:0]  r_mem2 [MAX_WIDTH];

    logic                         w_adv;
    logic [ADDR_W-1:0]            w_addr;
    logic [yuvbd_pkg::PIX_W-1:0]  w_pack;

    logic                         r_s1_valid;
    yuvbd_pkg::t_op               r_s1;
    logic [yuvbd_pkg::PIX_W-1:0]  r_rd0;
    logic [yuvbd_pkg::PIX_W-1:0]  r_rd1;
    logic [yuvbd_pkg::PIX_W-1:0]  r_rd2;

    logic                         r_s2_valid;
    yuvbd_pkg::t_kind             r_s2_kind;
    logic                         r_s2_restart;
    logic                         r_s2_emit;
    logic [yuvbd_pkg::ADD_W-1:0]  r_add_y, r_add_u, r_add_v;
    logic [yuvbd_pkg::ADD_W-1:0]  n_add_y, n_add_u, n_add_v;

    logic [yuvbd_pkg::SUM_W-1:0]  r_sum_y, r_sum_u, r_sum_v;
    logic [yuvbd_pkg::SUM_W-1:0]  n_sum_y, n_sum_u, n_sum_v;
    logic                         w_s2_acc;
    logic [SW-1:0]                n_luma, n_cb, n_cr;

    // The whole back pipeline moves together unless a result is stuck at the output.
    assign w_adv  = !o_tvalid || i_tready;
    assign o_pop  = w_adv && i_head_valid;
    assign w_addr = i_head.col[ADDR_W-1:0];
    assign w_pack = {i_head.cr, i_head.cb, i_head.luma};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd0 <= r_mem0[w_addr];
            r_rd1 <= r_mem1[w_addr];
            r_rd2 <= r_mem2[w_addr];
            if (i_head_valid && i_head.kind == yuvbd_pkg::KIND_STORE0) begin
                r_mem0[w_addr] <= w_pack;
            end
            if (i_head_valid && i_head.kind == yuvbd_pkg::KIND_STORE1) begin
                r_mem1[w_addr] <= w_pack;
            end
            if (i_head_valid && i_head.kind == yuvbd_pkg::KIND_STORE2) begin
                r_mem2[w_addr] <= w_pack;
            end
        end
    end

    // Column sum: current pixel plus, for accumulate items, the stored rows above it.
    always_comb begin
        logic acc;
        logic acc4;
        acc  = (r_s1.kind == yuvbd_pkg::KIND_ACC2) || (r_s1.kind == yuvbd_pkg::KIND_ACC4);
        acc4 = (r_s1.kind == yuvbd_pkg::KIND_ACC4);
        n_add_y = yuvbd_pkg::ADD_W'(r_s1.luma)
                + (acc  ? yuvbd_pkg::ADD_W'(r_rd0[SW-1:0]) : '0)
                + (acc4 ? yuvbd_pkg::ADD_W'(r_rd1[SW-1:0])
                        + yuvbd_pkg::ADD_W'(r_rd2[SW-1:0]) : '0);
        n_add_u = yuvbd_pkg::ADD_W'(r_s1.cb)
                + (acc  ? yuvbd_pkg::ADD_W'(r_rd0[2*SW-1:SW]) : '0)
                + (acc4 ? yuvbd_pkg::ADD_W'(r_rd1[2*SW-1:SW])
                        + yuvbd_pkg::ADD_W'(r_rd2[2*SW-1:SW]) : '0);
        n_add_v = yuvbd_pkg::ADD_W'(r_s1.cr)
                + (acc  ? yuvbd_pkg::ADD_W'(r_rd0[3*SW-1:2*SW]) : '0)
                + (acc4 ? yuvbd_pkg::ADD_W'(r_rd1[3*SW-1:2*SW])
                        + yuvbd_pkg::ADD_W'(r_rd2[3*SW-1:2*SW]) : '0);
    end

    assign w_s2_acc = (r_s2_kind == yuvbd_pkg::KIND_ACC2) || (r_s2_kind == yuvbd_pkg::KIND_ACC4);

    always_comb begin
        n_sum_y = (r_s2_restart ? '0 : r_sum_y) + yuvbd_pkg::SUM_W'(r_add_y);
        n_sum_u = (r_s2_restart ? '0 : r_sum_u) + yuvbd_pkg::SUM_W'(r_add_u);
        n_sum_v = (r_s2_restart ? '0 : r_sum_v) + yuvbd_pkg::SUM_W'(r_add_v);
        priority if (r_s2_kind == yuvbd_pkg::KIND_ACC4) begin
            n_luma = n_sum_y[SW+3:4];
            n_cb   = n_sum_u[SW+3:4];
            n_cr   = n_sum_v[SW+3:4];
        end else if (r_s2_kind == yuvbd_pkg::KIND_ACC2) begin
            n_luma = n_sum_y[SW+1:2];
            n_cb   = n_sum_u[SW+1:2];
            n_cr   = n_sum_v[SW+1:2];
        end else begin
            n_luma = r_add_y[SW-1:0];
            n_cb   = r_add_u[SW-1:0];
            n_cr   = r_add_v[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1         <= i_head;
            r_s2_kind    <= r_s1.kind;
            r_s2_restart <= r_s1.restart;
            r_s2_emit    <= r_s1.emit;
            r_add_y      <= n_add_y;
            r_add_u      <= n_add_u;
            r_add_v      <= n_add_v;
            o_luma       <= n_luma;
            o_cb         <= n_cb;
            o_cr         <= n_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_tvalid   <= 1'b0;
            r_sum_y    <= '0;
            r_sum_u    <= '0;
            r_sum_v    <= '0;
        end else if (w_adv) begin
            r_s1_valid <= i_head_valid;
            r_s2_valid <= r_s1_valid;
            o_tvalid   <= r_s2_valid && r_s2_emit;
            if (r_s2_valid && w_s2_acc) begin
                r_sum_y <= n_sum_y;
                r_sum_u <= n_sum_u;
                r_sum_v <= n_sum_v;
            end
        end
    end

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_tvalid) |-> $past(r_s2_valid && r_s2_emit))
        else $error("result raised without an emitting item behind it");

    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1.kind == yuvbd_pkg::KIND_STORE0 ||
                       r_s1.kind == yuvbd_pkg::KIND_STORE1 ||
                       r_s1.kind == yuvbd_pkg::KIND_STORE2) |-> !r_s1.emit)
        else $error("line store item marked to emit a result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !i_tready |=> $stable(r_s1_valid) && $stable(r_s2_valid))
        else $error("back pipeline moved while the output was stalled");

endmodule

// ----- sim/yuv_box_downscale_tb.sv -----
// Self-checking testbench for the YUV box downscaler: pass-through, 2x2 and 4x4 averaging.
`timescale 1ns / 1ps

module yuv_box_downscale_tb;

    localparam int CFG_IDX_W     = yuvbd_pkg::CFG_IDX_W;
    localparam int SAMPLE_W      = yuvbd_pkg::SAMPLE_W;
    localparam int DIM_W         = yuvbd_pkg::DIM_W;
    localparam int SUM_W         = yuvbd_pkg::SUM_W;
    localparam int PIX_W         = yuvbd_pkg::PIX_W;
    localparam int MAX_WIDTH_DEF = yuvbd_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT    = yuvbd_pkg::MAX_HEIGHT;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

    localparam logic [1:0] PATTERN_PLANAR = 2'd0;
    localparam logic [2:0] SCALE_BY_2     = 3'd2;
    localparam logic [2:0] SCALE_BY_4     = 3'd4;

    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 100;
    localparam int HOLD_EVERY    = 1500;
    localparam int HOLD_START    = 100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cr;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] luma;
    } t_pixel;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [31:0]          i_s_tdata   = '0;   // luma_in, cb_in, cr_in, zero pad
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [31:0]          o_m_tdata;          // luma_out, cb_out, cr_out, zero pad

    yuv_box_downscale uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the configuration registers and of the block's state.
    logic             cfg_enable;
    logic [1:0]       cfg_pattern;
    logic [2:0]       cfg_factor;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    int               col_pos;
    int               row_pos;
    t_pixel           line_a [MAX_WIDTH_DEF];
    t_pixel           line_b [MAX_WIDTH_DEF];
    t_pixel           line_c [MAX_WIDTH_DEF];
    logic [SUM_W-1:0] sum_y, sum_u, sum_v;

    t_pixel   pixels_to_send [$];
    t_pixel   expected_pixels [$];
    int       mismatches   = 0;
    int       result_count = 0;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_left    = 0;
    t_rx_mode rx_mode      = RX_ALWAYS;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return int'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SAMPLE_W'(SAMPLE_MAX);
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Works out what one accepted pixel produces and advances the raster position.
    task automatic downscale_pixel(input t_pixel px);
        int     w, h, blk, phase, shift;
        int     add_y, add_u, add_v;
        t_pixel res;
        bit     emit;
        w     = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h     = clamp_dim(cfg_height, MAX_HEIGHT);
        emit  = 1'b0;
        res   = px;
        if (!cfg_enable) begin
            emit = 1'b1;
        end else if (cfg_pattern == PATTERN_PLANAR &&
                     (cfg_factor == SCALE_BY_2 || cfg_factor == SCALE_BY_4)) begin
            blk   = (cfg_factor == SCALE_BY_4) ? 4 : 2;
            shift = (cfg_factor == SCALE_BY_4) ? 4 : 2;
            phase = row_pos % blk;
            if (phase == blk - 1) begin
                add_y = px.luma + line_a[col_pos].luma;
                add_u = px.cb   + line_a[col_pos].cb;
                add_v = px.cr   + line_a[col_pos].cr;
                if (blk == 4) begin
                    add_y += line_b[col_pos].luma + line_c[col_pos].luma;
                    add_u += line_b[col_pos].cb   + line_c[col_pos].cb;
                    add_v += line_b[col_pos].cr   + line_c[col_pos].cr;
                end
                if (col_pos % blk == 0) begin
                    sum_y = '0;
                    sum_u = '0;
                    sum_v = '0;
                end
                sum_y = SUM_W'(sum_y + add_y);
                sum_u = SUM_W'(sum_u + add_u);
                sum_v = SUM_W'(sum_v + add_v);
                if (col_pos % blk == blk - 1) begin
                    res.luma = SAMPLE_W'(sum_y >> shift);
                    res.cb   = SAMPLE_W'(sum_u >> shift);
                    res.cr   = SAMPLE_W'(sum_v >> shift);
                    emit     = 1'b1;
                end
            end else begin
                case (phase)
                    0:       line_a[col_pos] = px;
                    1:       line_b[col_pos] = px;
                    default: line_c[col_pos] = px;
                endcase
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        if (emit)
            expected_pixels.push_back(res);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                downscale_pixel(pixels_to_send.pop_front());
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pixels_to_send.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {2'b00, pixels_to_send[0]};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off now and then, so that the input side backs up.
    // The first one falls inside the long pass-through frame at the start.
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (cycle_count % HOLD_EVERY == HOLD_START)
            hold_left <= $urandom_range(100, 250);
    end

    always @(posedge i_clk) begin
        if (cycle_count % 64 == 0)
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_m_tready <= 1'b1;
                RX_RANDOM: i_m_tready <= ($urandom_range(0, 2) != 0);
                default:   i_m_tready <= (cycle_count % 5 < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pixel got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[PIX_W-1:0];
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d (Y %0d U %0d V %0d)",
                                          result_count, got.luma, got.cb, got.cr));
            end else begin
                want = expected_pixels.pop_front();
                if (got.luma !== want.luma)
                    report_mismatch($sformatf("result %0d luma %0d, expected %0d",
                                              result_count, got.luma, want.luma));
                if (got.cb !== want.cb)
                    report_mismatch($sformatf("result %0d cb %0d, expected %0d",
                                              result_count, got.cb, want.cb));
                if (got.cr !== want.cr)
                    report_mismatch($sformatf("result %0d cr %0d, expected %0d",
                                              result_count, got.cr, want.cr));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_ENABLE:  cfg_enable  = value[0];
            REG_PATTERN: cfg_pattern = value[1:0];
            REG_FACTOR:  cfg_factor  = value[2:0];
            REG_WIDTH:   cfg_width   = value;
            default:     cfg_height  = value;
        endcase
    endtask

    task automatic configure(input logic en, input logic [1:0] pat, input logic [2:0] fac,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(REG_ENABLE, DIM_W'(en));
        write_reg(REG_PATTERN, DIM_W'(pat));
        write_reg(REG_FACTOR, DIM_W'(fac));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Whole frames only, so that every phase starts at the top-left pixel.
    task automatic queue_frames(input int frames);
        int     n;
        t_pixel px;
        n = frames * clamp_dim(cfg_width, MAX_WIDTH_DEF) * clamp_dim(cfg_height, MAX_HEIGHT);
        repeat (n) begin
            px.luma = rand_sample();
            px.cb   = rand_sample();
            px.cr   = rand_sample();
            pixels_to_send.push_back(px);
        end
    endtask

    task automatic queue_flat(input int count, input t_pixel px);
        repeat (count) pixels_to_send.push_back(px);
    endtask

    // Items that give no result may still be in flight once nothing is expected.
    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int               random_items;
        logic             en;
        logic [1:0]       pat;
        logic [2:0]       fac;
        logic [DIM_W-1:0] w, h;
        col_pos      = 0;
        row_pos      = 0;
        sum_y        = '0;
        sum_u        = '0;
        sum_v        = '0;
        random_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pass-through of extreme and alternating samples, then a longer
        // pass-through frame that the output hold-off backs up into the input.
        configure(1'b0, PATTERN_PLANAR, SCALE_BY_2, 4, 1);
        queue_flat(1, '{cr: 10'h000, cb: 10'h000, luma: 10'h000});
        queue_flat(1, '{cr: 10'h3FF, cb: 10'h3FF, luma: 10'h3FF});
        queue_flat(1, '{cr: 10'h155, cb: 10'h2AA, luma: 10'h155});
        queue_flat(1, '{cr: 10'h2AA, cb: 10'h155, luma: 10'h2AA});
        wait_idle();
        configure(1'b0, PATTERN_PLANAR, SCALE_BY_2, 16, 16);
        queue_frames(1);
        wait_idle();

        // Full-scale blocks.
        configure(1'b1, PATTERN_PLANAR, SCALE_BY_2, 2, 2);
        queue_flat(4, '{cr: 10'h3FF, cb: 10'h3FF, luma: 10'h3FF});
        wait_idle();
        configure(1'b1, PATTERN_PLANAR, SCALE_BY_4, 4, 4);
        queue_flat(16, '{cr: 10'h3FF, cb: 10'h3FF, luma: 10'h3FF});
        wait_idle();

        // Longer rows through all three line stores, then a zero width.
        configure(1'b1, PATTERN_PLANAR, SCALE_BY_4, 64, 4);
        queue_frames(1);
        wait_idle();
        configure(1'b1, PATTERN_PLANAR, SCALE_BY_4, 0, 8);
        queue_frames(1);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            en  = ($urandom_range(0, 5) != 0);
            pat = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : PATTERN_PLANAR;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: fac = SCALE_BY_2;
                4, 5, 6, 7: fac = SCALE_BY_4;
                default:    fac = 3'($urandom_range(0, 7));
            endcase
            w = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 12));
            h = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 9));
            configure(en, pat, fac, w, h);
            queue_frames($urandom_range(1, 3));
            random_items += pixels_to_send.size();
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/yuvbd_pkg.sv
rtl/yuvbd_front.sv
rtl/yuvbd_queue.sv
rtl/yuvbd_back.sv
rtl/yuv_box_downscale.sv
sim/yuv_box_downscale_tb.sv
